// File: rtl/core/bsc_pkg.sv
// Shared types and constants for the barometric sensor compensation block.
package bsc_pkg;

    localparam logic [1:0] CFG_TEMP_CAL  = 2'd0;
    localparam logic [1:0] CFG_PRESS_LO  = 2'd1;
    localparam logic [1:0] CFG_PRESS_MID = 2'd2;
    localparam logic [1:0] CFG_PRESS_HI  = 2'd3;

    localparam logic signed [63:0] TFINE_OFFSET = 64'sd128000;
    localparam logic [20:0]        RAW_FULL     = 21'd1048576;
    localparam logic signed [63:0] PRESS_SCALE  = 64'sd3125;
    localparam logic signed [63:0] P1_BIAS      = 64'sd140737488355328;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
    } t_tcal;

    typedef struct packed {
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_pcal;

    typedef struct packed {
        logic [19:0]        raw_p;
        logic signed [31:0] tfine;
        logic signed [15:0] temp;
    } t_qent;

endpackage

// File: rtl/core/baro_sensor_compensation.sv
// Top level of the barometric sensor compensation block.
// Each transaction carries a raw 20-bit pressure and temperature reading pair and yields
// one result: temperature in 0.01 degC (saturated, 16 bits), pressure in Pa as unsigned
// Q24.8 and a flag that is set when the pressure divisor was zero (pressure is then 0).
// Calibration words are to be written through the configuration port only while the block
// is idle; the block itself does not enforce this. The front end computes temperature in a
// three-stage pipeline and takes a new reading every cycle while queue space remains; the
// queue holds QUEUE_DEPTH readings. The back end runs ten 64-bit multiplications on one
// shared multiplier and a radix-2 divider, and takes a new reading from the queue only once
// the previous result has been handed to the output. When the divisor is zero the divider
// and the last four multiplications are skipped.
module baro_sensor_compensation
    import bsc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [19:0] i_raw_pressure,
    input  logic [19:0] i_raw_temperature,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_pressure_pa_q8,
    output logic signed [15:0] o_temperature_centi,
    output logic        o_divisor_zero
);
    logic [47:0] r_tcal;
    logic [63:0] r_plo, r_pmid;
    logic [15:0] r_phi;

    t_tcal tcal;
    t_pcal pcal;
    t_qent push_data, head;
    logic  push, pop, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcal <= '0;
            r_plo  <= '0;
            r_pmid <= '0;
            r_phi  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TEMP_CAL:  r_tcal <= i_cfg_data[47:0];
                CFG_PRESS_LO:  r_plo  <= i_cfg_data;
                CFG_PRESS_MID: r_pmid <= i_cfg_data;
                CFG_PRESS_HI:  r_phi  <= i_cfg_data[15:0];
                default:       r_phi  <= r_phi;
            endcase
        end
    end

    assign tcal.t1 = r_tcal[15:0];
    assign tcal.t2 = r_tcal[31:16];
    assign tcal.t3 = r_tcal[47:32];
    assign pcal.p1 = r_plo[15:0];
    assign pcal.p2 = r_plo[31:16];
    assign pcal.p3 = r_plo[47:32];
    assign pcal.p4 = r_plo[63:48];
    assign pcal.p5 = r_pmid[15:0];
    assign pcal.p6 = r_pmid[31:16];
    assign pcal.p7 = r_pmid[47:32];
    assign pcal.p8 = r_pmid[63:48];
    assign pcal.p9 = r_phi;

    bsc_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_tcal            (tcal),
        .i_valid           (i_in_valid),
        .o_stall           (o_in_stall),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .i_pop             (pop),
        .o_push            (push),
        .o_push_data       (push_data)
    );

    bsc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (head)
    );

    bsc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_pcal              (pcal),
        .i_empty             (empty),
        .i_entry             (head),
        .o_pop               (pop),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_pressure_pa_q8    (o_pressure_pa_q8),
        .o_temperature_centi (o_temperature_centi),
        .o_divisor_zero      (o_divisor_zero)
    );
endmodule

// File: rtl/core/bsc_front.sv
// Front end: accepts readings, computes the temperature and fine temperature in a pipeline.
module bsc_front
    import bsc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_tcal       i_tcal,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [19:0] i_raw_pressure,
    input  logic [19:0] i_raw_temperature,
    input  logic        i_pop,
    output logic        o_push,
    output t_qent       o_push_data
);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] r_credit;
    logic          accept;

    logic r1_v, r2_v, r3_v;
    logic signed [31:0] r1_at, r1_bb, r2_v1, r2_v2p, r3_tfine;
    logic [19:0] r1_p, r2_p, r3_p;

    logic signed [18:0] a;
    logic signed [17:0] b;
    logic signed [34:0] at_full;
    logic signed [35:0] bb_full;
    logic signed [31:0] bsh;
    logic signed [47:0] v2_full;
    logic signed [31:0] tfine;
    logic signed [31:0] t5;
    logic signed [31:0] tt;
    logic signed [15:0] tsat;

    // Credits count queue slots, including those held by items still in the pipeline.
    assign o_stall = (r_credit == CW'(QUEUE_DEPTH));
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            case ({accept, i_pop})
                2'b10:   r_credit <= r_credit + 1'b1;
                2'b01:   r_credit <= r_credit - 1'b1;
                default: r_credit <= r_credit;
            endcase
        end
    end

    always_comb begin
        a       = $signed({2'b00, i_raw_temperature[19:3]}) - $signed({2'b00, i_tcal.t1, 1'b0});
        b       = $signed({2'b00, i_raw_temperature[19:4]}) - $signed({2'b00, i_tcal.t1});
        at_full = a * i_tcal.t2;
        bb_full = b * b;
        bsh     = r1_bb >>> 12;
        v2_full = bsh * i_tcal.t3;
        tfine   = r2_v1 + (r2_v2p >>> 14);
        t5      = (r3_tfine <<< 2) + r3_tfine + 32'sd128;
        tt      = t5 >>> 8;
        if (tt > 32'sd32767) begin
            tsat = 16'sh7fff;
        end else if (tt < -32'sd32768) begin
            tsat = 16'sh8000;
        end else begin
            tsat = tt[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= accept;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_at    <= at_full[31:0];
        r1_bb    <= bb_full[31:0];
        r1_p     <= i_raw_pressure;
        r2_v1    <= r1_at >>> 11;
        r2_v2p   <= v2_full[31:0];
        r2_p     <= r1_p;
        r3_tfine <= tfine;
        r3_p     <= r2_p;
    end

    assign o_push            = r3_v;
    assign o_push_data.raw_p = r3_p;
    assign o_push_data.tfine = r3_tfine;
    assign o_push_data.temp  = tsat;
endmodule

// File: rtl/core/bsc_queue.sv
// Short queue between the front and back ends.
module bsc_queue
    import bsc_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_data,
    input  logic  i_pop,
    output logic  o_empty,
    output t_qent o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_qent          r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// File: rtl/core/bsc_mul.sv
// Wrapping 64-bit multiplier built from three 32x32 partial products computed one after another.
module bsc_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_p
);
    logic [63:0] r_a, r_b, r_acc, r_prod;
    logic [1:0]  r_cnt;
    logic        r_busy, r_done;
    logic [31:0] op_a, op_b;

    always_comb begin
        case (r_cnt)
            2'd0:    begin op_a = r_a[31:0];  op_b = r_b[31:0];  end
            2'd1:    begin op_a = r_a[31:0];  op_b = r_b[63:32]; end
            default: begin op_a = r_a[63:32]; op_b = r_b[31:0];  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_busy) begin
            case (r_cnt)
                2'd1:    r_acc <= r_prod;
                2'd2:    r_acc <= r_acc + {r_prod[31:0], 32'd0};
                2'd3:    r_acc <= r_acc + {r_prod[31:0], 32'd0};
                default: r_acc <= r_acc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == 2'd3);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

// File: rtl/core/bsc_div.sv
// Signed 64-bit divider, truncating towards zero, one quotient bit per cycle.
module bsc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [63:0] i_den,
    output logic               o_done,
    output logic signed [63:0] o_q
);
    logic [63:0] r_rem, r_quo, r_den;
    logic        r_neg, r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [64:0] trial;
    logic        ge;

    assign trial = {r_rem, r_quo[63]};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num[63] ? 64'(-i_num) : i_num;
            r_den <= i_den[63] ? 64'(-i_den) : i_den;
            r_neg <= i_num[63] ^ i_den[63];
        end else if (r_busy) begin
            r_rem <= ge ? 64'(trial - {1'b0, r_den}) : trial[63:0];
            r_quo <= {r_quo[62:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == 6'd63);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_neg ? -$signed(r_quo) : $signed(r_quo);
endmodule

// File: rtl/core/bsc_back.sv
// Back end: sequences the 64-bit pressure compensation on a shared multiplier and a divider.
module bsc_back
    import bsc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_pcal        i_pcal,
    input  logic         i_empty,
    input  t_qent        i_entry,
    output logic         o_pop,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic [31:0]  o_pressure_pa_q8,
    output logic signed [15:0] o_temperature_centi,
    output logic         o_divisor_zero
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    typedef enum logic [3:0] {
        SP_V1SQ, SP_P6, SP_P5, SP_P3, SP_P2, SP_P1, SP_NUM, SP_P9A, SP_P9B, SP_P8
    } t_step;

    t_state r_state, n_state;
    t_step  r_step, n_step;
    logic   r_go, r_div_go;
    logic   n_go, n_div_go, n_out_valid, fin_load;

    logic signed [63:0] r_v1, r_m1, r_v2, r_acc, r_den, r_num, r_p, r_t;
    logic [19:0]        r_rawp;
    logic signed [15:0] r_temp;
    logic [31:0]        r_press;
    logic               r_flag;

    logic [63:0]        mul_a, mul_b, mul_p;
    logic               mul_done, div_done;
    logic signed [63:0] div_q, mp, q13, sum;

    assign mp  = $signed(mul_p);
    assign q13 = r_p >>> 13;

    always_comb begin
        case (r_step)
            SP_V1SQ: begin mul_a = r_v1; mul_b = r_v1; end
            SP_P6:   begin mul_a = r_m1; mul_b = 64'(i_pcal.p6); end
            SP_P5:   begin mul_a = r_v1; mul_b = 64'(i_pcal.p5); end
            SP_P3:   begin mul_a = r_m1; mul_b = 64'(i_pcal.p3); end
            SP_P2:   begin mul_a = r_v1; mul_b = 64'(i_pcal.p2); end
            SP_P1:   begin mul_a = P1_BIAS + r_acc; mul_b = {48'd0, i_pcal.p1}; end
            SP_NUM:  begin
                mul_a = ({43'd0, 21'(RAW_FULL - {1'b0, r_rawp})} << 31) - r_v2;
                mul_b = PRESS_SCALE;
            end
            SP_P9A:  begin mul_a = 64'(i_pcal.p9); mul_b = q13; end
            SP_P9B:  begin mul_a = r_t; mul_b = q13; end
            SP_P8:   begin mul_a = 64'(i_pcal.p8); mul_b = r_p; end
            default: begin mul_a = r_v1; mul_b = r_v1; end
        endcase
        sum = r_p + r_acc + (mp >>> 19);
    end

    bsc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    bsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    assign o_pop    = (r_state == ST_IDLE) && !i_empty;
    assign fin_load = (r_state == ST_FIN) && (!o_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_v1   <= 64'(i_entry.tfine) - TFINE_OFFSET;
            r_rawp <= i_entry.raw_p;
            r_temp <= i_entry.temp;
            r_flag <= 1'b0;
        end
        if (div_done) begin
            r_p <= div_q;
        end
        if (mul_done) begin
            case (r_step)
                SP_V1SQ: r_m1  <= mp;
                SP_P6:   r_v2  <= mp;
                SP_P5:   r_v2  <= r_v2 + (mp <<< 17) + (64'(i_pcal.p4) <<< 35);
                SP_P3:   r_acc <= mp >>> 8;
                SP_P2:   r_acc <= r_acc + (mp <<< 12);
                SP_P1:   begin
                    r_den   <= mp >>> 33;
                    r_flag  <= ((mp >>> 33) == 64'sd0);
                    r_press <= '0;
                end
                SP_NUM:  r_num <= mp;
                SP_P9A:  r_t   <= mp;
                SP_P9B:  r_acc <= mp >>> 25;
                SP_P8:   r_press <= 32'((sum >>> 8) + (64'(i_pcal.p7) <<< 4));
                default: r_t <= r_t;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_go        = 1'b0;
        n_div_go    = 1'b0;
        n_out_valid = o_out_valid && i_out_stall;
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    n_state = ST_MUL;
                    n_step  = SP_V1SQ;
                    n_go    = 1'b1;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    case (r_step)
                        SP_P1: begin
                            if ((mp >>> 33) == 64'sd0) begin
                                n_state = ST_FIN;
                            end else begin
                                n_step = SP_NUM;
                                n_go   = 1'b1;
                            end
                        end
                        SP_NUM: begin
                            n_state  = ST_DIV;
                            n_div_go = 1'b1;
                        end
                        SP_P8: n_state = ST_FIN;
                        default: begin
                            n_step = t_step'(r_step + 4'd1);
                            n_go   = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_MUL;
                    n_step  = SP_P9A;
                    n_go    = 1'b1;
                end
            end
            ST_FIN: begin
                if (fin_load) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= SP_V1SQ;
            r_go        <= 1'b0;
            r_div_go    <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_go        <= n_go;
            r_div_go    <= n_div_go;
            o_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_load) begin
            o_pressure_pa_q8    <= r_press;
            o_temperature_centi <= r_temp;
            o_divisor_zero      <= r_flag;
        end
    end
endmodule
